/* rtl/iba_pkg.sv */
// Package for the indexed block allocator: shared constants, status codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
package iba_pkg;

  localparam int NUM_BLOCKS_DEF = 32;
  localparam int DIR_SLOTS_DEF  = 32;
  localparam int DATA_IDX_W     = 6;   // data block position within a file
  localparam int MAX_DATA       = 2 ** DATA_IDX_W;
  localparam int NAME_W         = 8;
  localparam int COUNT_W        = 6;
  localparam int STATUS_W       = 3;
  localparam int BLOCK_OUT_W    = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_NO_INDEX  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_DIR_FULL  = 3'd3,
    ST_DELETED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic {
    OP_CREATE = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BSEL_NONE,
    BSEL_INDEX,
    BSEL_SCAN
  } blk_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_PUT_INDEX,
    S_ALLOC,
    S_DEL_RD,
    S_DEL_CHK,
    S_FREE_CHK,
    S_FREE_CLR,
    S_REPORT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     scan;
    logic     clr_j;
    logic     step_j;
    logic     take_index;
    logic     take_data;
    logic     free_index;
    logic     free_data;
    logic     release_slot;
    logic     put;
    status_t  code;
    blk_sel_t blk_sel;
    logic     is_index;
    logic     last;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic found_ib;
    logic enough;
    logic found_slot;
    logic want_zero;
    logic blk_free;
    logic data_last;
    logic slot_match;
    logic slot_last;
    logic free_done;
    logic out_space;
  } dp_stat_t;

endpackage

/* rtl/iba_req_if.sv */
// Request channel interface: valid/ready handshake with the request payload.
// Depends on iba_pkg.
`timescale 1ns / 1ps
interface iba_req_if import iba_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [NAME_W-1:0]    file_name;
  logic [COUNT_W-1:0]   block_count;

  modport source(output valid, op, file_name, block_count, input ready);
  modport sink(input valid, op, file_name, block_count, output ready);
endinterface

/* rtl/iba_rsp_if.sv */
// Result channel interface: valid/ready handshake with the result payload.
// Depends on iba_pkg.
`timescale 1ns / 1ps
interface iba_rsp_if import iba_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [BLOCK_OUT_W-1:0] block_number;
  logic                   is_index;
  logic                   last;

  modport source(output valid, status, block_number, is_index, last, input ready);
  modport sink(input valid, status, block_number, is_index, last, output ready);
endinterface

/* rtl/iba_datapath.sv */
// Datapath: free map, directory storage, scan counters and result register.
// Depends on iba_pkg; driven by iba_ctrl through ctl_cmd_t / dp_stat_t.
`timescale 1ns / 1ps
module iba_datapath import iba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int DIR_SLOTS  = DIR_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [NAME_W-1:0]      in_file_name,
  input  logic [COUNT_W-1:0]     in_block_count,
  input  ctl_cmd_t               cmd,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [BLOCK_OUT_W-1:0] out_block_number,
  output logic                   out_is_index,
  output logic                   out_last
);

  localparam int BW     = $clog2(NUM_BLOCKS);
  localparam int SW     = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int SCAN_N = (NUM_BLOCKS > DIR_SLOTS) ? NUM_BLOCKS : DIR_SLOTS;
  localparam int JW     = $clog2(SCAN_N);
  localparam int CW     = $clog2(NUM_BLOCKS + 1);
  localparam int CMPW   = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
  localparam int AW     = SW + DATA_IDX_W;
  localparam int SLOT_W = NAME_W + BW + COUNT_W;

  // Request registers
  logic [NAME_W-1:0]     name_r;
  logic [COUNT_W-1:0]    want_r;

  // Scan state
  logic [JW-1:0]         j_r;
  logic [DATA_IDX_W-1:0] k_r;
  logic [BW-1:0]         ib_r;
  logic                  found_ib_r;
  logic [CW-1:0]         free_cnt_r;
  logic [SW-1:0]         slot_r;
  logic                  found_slot_r;

  // Free map and directory valid bits
  logic [NUM_BLOCKS-1:0] busy_r;
  logic [DIR_SLOTS-1:0]  used_r;

  // Directory entry memory {name, index block, count} and data block memory
  logic [SLOT_W-1:0]     slot_mem [DIR_SLOTS];
  logic [SLOT_W-1:0]     slot_q_r;
  logic [BW-1:0]         dmem [DIR_SLOTS*MAX_DATA];
  logic [BW-1:0]         dmem_q_r;

  // Result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [BLOCK_OUT_W-1:0] out_block_r;
  logic                  out_is_index_r;
  logic                  out_last_r;

  logic [BW-1:0]         blk_idx;
  logic [SW-1:0]         slot_idx;
  logic                  j_in_blk;
  logic                  j_in_dir;
  logic                  blk_free;
  logic                  slot_free;
  logic [NAME_W-1:0]     q_name;
  logic [BW-1:0]         q_idx;
  logic [COUNT_W-1:0]    q_cnt;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [BW-1:0]         blk_sel_val;
  logic [BW+BLOCK_OUT_W-1:0] blk_wide;

  // Decode scan position
  assign blk_idx   = j_r[BW-1:0];
  assign slot_idx  = j_r[SW-1:0];
  assign j_in_blk  = ({1'b0, j_r} < (JW+1)'(NUM_BLOCKS));
  assign j_in_dir  = ({1'b0, j_r} < (JW+1)'(DIR_SLOTS));
  assign blk_free  = j_in_blk && !busy_r[blk_idx];
  assign slot_free = j_in_dir && !used_r[slot_idx];

  assign q_name = slot_q_r[SLOT_W-1 -: NAME_W];
  assign q_idx  = slot_q_r[BW+COUNT_W-1 -: BW];
  assign q_cnt  = slot_q_r[COUNT_W-1:0];

  assign wr_addr = {slot_r, k_r};
  assign rd_addr = {slot_idx, k_r};

  // Status back to the controller
  always_comb begin
    stat            = '0;
    stat.scan_last  = (j_r == JW'(SCAN_N - 1));
    stat.found_ib   = found_ib_r;
    stat.enough     = (CMPW'(free_cnt_r) > CMPW'(want_r));
    stat.found_slot = found_slot_r;
    stat.want_zero  = (want_r == '0);
    stat.blk_free   = blk_free;
    stat.data_last  = ((k_r + DATA_IDX_W'(1)) == want_r);
    stat.slot_match = used_r[slot_idx] && (q_name == name_r);
    stat.slot_last  = (j_r == JW'(DIR_SLOTS - 1));
    stat.free_done  = (k_r == q_cnt);
    stat.out_space  = !out_valid_r || out_ready;
  end

  // Latch request, advance scan and position counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      name_r       <= in_file_name;
      want_r       <= in_block_count;
      j_r          <= '0;
      k_r          <= '0;
      found_ib_r   <= 1'b0;
      free_cnt_r   <= '0;
      found_slot_r <= 1'b0;
    end else begin
      if (cmd.scan) begin
        if (blk_free && !found_ib_r) begin
          ib_r       <= blk_idx;
          found_ib_r <= 1'b1;
        end
        if (blk_free) begin
          free_cnt_r <= free_cnt_r + CW'(1);
        end
        if (slot_free && !found_slot_r) begin
          slot_r       <= slot_idx;
          found_slot_r <= 1'b1;
        end
      end
      if (cmd.clr_j) begin
        j_r <= '0;
      end else if (cmd.scan || cmd.step_j) begin
        j_r <= j_r + JW'(1);
      end
      if (cmd.take_data || cmd.free_data) begin
        k_r <= k_r + DATA_IDX_W'(1);
      end
    end
  end

  // Update free map and directory valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      used_r <= '0;
    end else begin
      if (cmd.take_index) begin
        busy_r[ib_r]   <= 1'b1;
        used_r[slot_r] <= 1'b1;
      end
      if (cmd.take_data) begin
        busy_r[blk_idx] <= 1'b1;
      end
      if (cmd.free_index) begin
        busy_r[q_idx] <= 1'b0;
      end
      if (cmd.free_data) begin
        busy_r[dmem_q_r] <= 1'b0;
      end
      if (cmd.release_slot) begin
        used_r[slot_idx] <= 1'b0;
      end
    end
  end

  // Directory entry memory, registered read at the scan slot
  always_ff @(posedge clk) begin
    if (cmd.take_index) begin
      slot_mem[slot_r] <= {name_r, ib_r, want_r};
    end
    slot_q_r <= slot_mem[slot_idx];
  end

  // Data block memory, registered read at the scan slot and position
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      dmem[wr_addr] <= blk_idx;
    end
    dmem_q_r <= dmem[rd_addr];
  end

  // Select the block number of a result
  always_comb begin
    unique case (cmd.blk_sel)
      BSEL_INDEX: blk_sel_val = ib_r;
      BSEL_SCAN:  blk_sel_val = blk_idx;
      default:    blk_sel_val = '0;
    endcase
    blk_wide = {{BLOCK_OUT_W{1'b0}}, blk_sel_val};
  end

  // Result register: load on put, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_status_r   <= cmd.code;
      out_block_r    <= blk_wide[BLOCK_OUT_W-1:0];
      out_is_index_r <= cmd.is_index;
      out_last_r     <= cmd.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_number = out_block_r;
  assign out_is_index     = out_is_index_r;
  assign out_last         = out_last_r;

endmodule

/* rtl/iba_ctrl.sv */
// Controller state machine: sequences scan, allocation, lookup and release.
// Depends on iba_pkg; drives iba_datapath through ctl_cmd_t.
`timescale 1ns / 1ps
module iba_ctrl import iba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  // State and pending report code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_CREATED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_DELETE) ? S_DEL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!stat.found_ib) begin
          code_nxt  = ST_NO_INDEX;
          state_nxt = S_REPORT;
        end else if (!stat.enough) begin
          code_nxt  = ST_NO_SPACE;
          state_nxt = S_REPORT;
        end else if (!stat.found_slot) begin
          code_nxt  = ST_DIR_FULL;
          state_nxt = S_REPORT;
        end else begin
          cmd.clr_j = 1'b1;
          state_nxt = S_PUT_INDEX;
        end
      end
      S_PUT_INDEX: begin
        if (stat.out_space) begin
          cmd.take_index = 1'b1;
          cmd.put        = 1'b1;
          cmd.code       = ST_CREATED;
          cmd.blk_sel    = BSEL_INDEX;
          cmd.is_index   = 1'b1;
          cmd.last       = stat.want_zero;
          state_nxt      = stat.want_zero ? S_IDLE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (!stat.blk_free) begin
          cmd.step_j = 1'b1;
        end else if (stat.out_space) begin
          cmd.take_data = 1'b1;
          cmd.put       = 1'b1;
          cmd.code      = ST_CREATED;
          cmd.blk_sel   = BSEL_SCAN;
          cmd.last      = stat.data_last;
          cmd.step_j    = 1'b1;
          if (stat.data_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DEL_RD: begin
        state_nxt = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        priority if (stat.slot_match) begin
          cmd.free_index = 1'b1;
          state_nxt      = S_FREE_CHK;
        end else if (stat.slot_last) begin
          code_nxt  = ST_NOT_FOUND;
          state_nxt = S_REPORT;
        end else begin
          cmd.step_j = 1'b1;
          state_nxt  = S_DEL_RD;
        end
      end
      S_FREE_CHK: begin
        if (stat.free_done) begin
          cmd.release_slot = 1'b1;
          code_nxt         = ST_DELETED;
          state_nxt        = S_REPORT;
        end else begin
          state_nxt = S_FREE_CLR;
        end
      end
      S_FREE_CLR: begin
        cmd.free_data = 1'b1;
        state_nxt     = S_FREE_CHK;
      end
      S_REPORT: begin
        if (stat.out_space) begin
          cmd.put     = 1'b1;
          cmd.code    = code_r;
          cmd.blk_sel = BSEL_NONE;
          cmd.last    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/indexed_block_allocator.sv */
// Top level of the indexed block allocator: controller plus datapath.
// Depends on iba_pkg, iba_req_if, iba_rsp_if, iba_ctrl, iba_datapath.
//
//   Channel  Dir  Signals                                     Meaning
//   in_ch    in   valid ready op file_name block_count        create/delete request
//   out_ch   out  valid ready status block_number is_index last  result transactions
//
// Create: accept, a scan of max(NUM_BLOCKS, DIR_SLOTS) positions, a decision, the index
// result, then a walk over free-map positions for data blocks (at most NUM_BLOCKS);
// an error reports from S_REPORT after the decision. Delete: accept, a read and a check
// (S_DEL_RD, S_DEL_CHK) per directory slot searched, a check and a clear (S_FREE_CHK,
// S_FREE_CLR) per data block freed, then a final check and the report.
// Reset is synchronous and active low; it frees every block and empties the
// directory at once, no clearing pass. A stalled result holds the sequencer
// but a new request is taken as soon as the previous one has issued its last result.
`timescale 1ns / 1ps
module indexed_block_allocator import iba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int DIR_SLOTS  = DIR_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  iba_req_if.sink   in_ch,
  iba_rsp_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  iba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .DIR_SLOTS  (DIR_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_file_name     (in_ch.file_name),
    .in_block_count   (in_ch.block_count),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_block_number (out_ch.block_number),
    .out_is_index     (out_ch.is_index),
    .out_last         (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule

/* rtl/iba_checker.sv */
// Port-level checker for the indexed block allocator, bound to the top level.
// Depends on iba_pkg.
`timescale 1ns / 1ps
module iba_checker import iba_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    out_status,
  input logic [BLOCK_OUT_W-1:0] out_block_number,
  input logic                   out_is_index,
  input logic                   out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_block_number) && $stable(out_is_index) && $stable(out_last))
    else $error("stalled result changed");

  // Error and delete results are single, blockless transactions
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_CREATED) |->
      out_last && !out_is_index && (out_block_number == '0))
    else $error("non-create result malformed");

  // Index marker only on created results
  a_index_created: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_index |-> (out_status == ST_CREATED))
    else $error("index marker on non-create result");

  // Drop ready after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind indexed_block_allocator iba_checker u_iba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_block_number (out_ch.block_number),
  .out_is_index     (out_ch.is_index),
  .out_last         (out_ch.last)
);
